// ----- design/patch_slot_residency_cache_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the patch slot residency cache
// Shared helpers that tie every check to the block clock and reset.
// ---------------------------------------------------------------------------
`ifndef PATCH_SLOT_RESIDENCY_CACHE_TOP_MACROS_SVH
`define PATCH_SLOT_RESIDENCY_CACHE_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define PSRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define PSRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/psrc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Patch slot residency cache package
// Beat types, codes and the records that travel along the cell chains.
// ---------------------------------------------------------------------------
package psrc_pkg;

   localparam int TIERS_DEF   = 4;
   localparam int SLOTS_DEF   = 16;
   localparam int PENDING_DEF = 16;

   // Widths that cover the largest legal table sizes (64 slots, 64 pending entries).
   localparam int IDX_W   = 6;
   localparam int COUNT_W = 7;

   localparam logic [31:0] TIMEOUT_RESET = 32'd60;

   typedef enum logic [1:0] {
      K_SYNC = 2'd0,
      K_ASYNC = 2'd1,
      K_BAKE = 2'd2,
      K_TICK = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_HIT = 3'd0,
      ST_FILLED = 3'd1,
      ST_ISSUED = 3'd2,
      ST_PENDING = 3'd3,
      ST_REFUSED = 3'd4,
      ST_BAD_TIER = 3'd5,
      ST_TICK_DONE = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  tier;
      logic [63:0] lookup_key;
      logic        queue_accepts;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [4:0] resident_count;
   } rsp_type;

   typedef struct packed {
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic               empty;
      logic [IDX_W-1:0]   empty_idx;
      logic [31:0]        min_stamp;
      logic [IDX_W-1:0]   min_idx;
      logic [COUNT_W-1:0] count;
   } slot_rec_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
      logic             expired;
      logic             free;
      logic [IDX_W-1:0] free_idx;
   } pend_rec_type;

endpackage

// ----- design/psrc_slot_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot cell
// Holds one slot position for every tier and folds it into the search record.
// ---------------------------------------------------------------------------
module psrc_slot_cell #(
   parameter int TIERS = psrc_pkg::TIERS_DEF,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [((TIERS > 1) ? $clog2(TIERS) : 1)-1:0] tier_idx,
   input  logic                  tier_ok,
   input  logic [63:0]           key,
   input  psrc_pkg::slot_rec_type rec_i,
   output psrc_pkg::slot_rec_type rec_o,
   input  logic                  touch_en,
   input  logic                  fill_en,
   input  logic [31:0]           stamp
);
   import psrc_pkg::*;

   logic        valid_ff [TIERS];
   logic [63:0] key_ff   [TIERS];
   logic [31:0] stamp_ff [TIERS];

   logic         v;
   slot_rec_type rec_in;
   slot_rec_type rec_ff;

   assign v = tier_ok && valid_ff[tier_idx];

   always_comb begin
      rec_in = rec_i;
      if (v && (key_ff[tier_idx] == key) && !rec_i.hit) begin
         rec_in.hit     = 1'b1;
         rec_in.hit_idx = IDX_W'(INDEX);
      end
      if (!v && !rec_i.empty) begin
         rec_in.empty     = 1'b1;
         rec_in.empty_idx = IDX_W'(INDEX);
      end
      // Strict compare keeps the earliest slot on equal stamps.
      if (stamp_ff[tier_idx] < rec_i.min_stamp) begin
         rec_in.min_stamp = stamp_ff[tier_idx];
         rec_in.min_idx   = IDX_W'(INDEX);
      end
      rec_in.count = rec_i.count + COUNT_W'(v);
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         for (int t = 0; t < TIERS; t++) begin
            valid_ff[t] <= 1'b0;
         end
      end else if (fill_en) begin
         valid_ff[tier_idx] <= 1'b1;
      end
      if (fill_en) begin
         key_ff[tier_idx] <= key;
      end
      if (fill_en || touch_en) begin
         stamp_ff[tier_idx] <= stamp;
      end
   end

   assign rec_o = rec_ff;

endmodule

// ----- design/psrc_pend_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pending cell
// Holds one in-flight bake request and folds it into the pending record.
// ---------------------------------------------------------------------------
module psrc_pend_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             tier,
   input  logic [63:0]            key,
   input  logic [31:0]            frame,
   input  logic [31:0]            timeout,
   input  psrc_pkg::pend_rec_type rec_i,
   output psrc_pkg::pend_rec_type rec_o,
   input  logic                   clear_en,
   input  logic                   mark_en
);
   import psrc_pkg::*;

   logic        used_ff;
   logic [2:0]  tier_ff;
   logic [63:0] key_ff;
   logic [31:0] mark_ff;

   logic         first;
   logic         expired;
   logic [31:0]  age;
   pend_rec_type rec_in;
   pend_rec_type rec_ff;

   assign age     = frame - mark_ff;
   assign expired = age > timeout;
   assign first   = used_ff && (tier_ff == tier) && (key_ff == key) && !rec_i.found;

   always_comb begin
      rec_in = rec_i;
      if (first) begin
         rec_in.found   = 1'b1;
         rec_in.idx     = IDX_W'(INDEX);
         rec_in.expired = expired;
      end
      // An expired first match counts as free, since it is released before a new mark.
      if ((!used_ff || (first && expired)) && !rec_i.free) begin
         rec_in.free     = 1'b1;
         rec_in.free_idx = IDX_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         used_ff <= 1'b0;
      end else if (mark_en) begin
         used_ff <= 1'b1;
      end else if (clear_en) begin
         used_ff <= 1'b0;
      end
      if (mark_en) begin
         tier_ff <= tier;
         key_ff  <= key;
         mark_ff <= frame;
      end
   end

   assign rec_o = rec_ff;

endmodule

// ----- design/patch_slot_residency_cache_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Patch slot residency cache
// Per-tier associative slot table with LRU fill and a pending request table.
// ---------------------------------------------------------------------------
// Usage: one request beat on req_* (kind, tier, lookup_key, queue_accepts)
// yields exactly one response beat on rsp_* (status, slot, resident_count).
// csr_* writes the pending timeout; write it only while the block is idle.
// Each request is walked through a row of slot cells and a row of pending
// cells, one cell per cycle; the walk runs the length of the longer chain,
// and a new request is taken only once the previous one is complete.
// req_stall is high from accept until the result is written to the output
// register. A stalled response is held in that register while the next
// request is already searched; the update then waits for the register.
// Synchronous reset empties every slot and pending entry, zeroes the use and
// frame counters and sets the timeout to 60 frames; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "patch_slot_residency_cache_top_macros.svh"

module patch_slot_residency_cache_top #(
   parameter int TIERS   = psrc_pkg::TIERS_DEF,
   parameter int SLOTS   = psrc_pkg::SLOTS_DEF,
   parameter int PENDING = psrc_pkg::PENDING_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psrc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import psrc_pkg::*;

   localparam int TIW   = (TIERS > 1) ? $clog2(TIERS) : 1;
   localparam int WALK  = (SLOTS > PENDING) ? SLOTS : PENDING;
   localparam int CNT_W = (WALK > 1) ? $clog2(WALK) : 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] walk_cnt_ff, walk_cnt_in;
   req_type     item_ff;
   logic [31:0] use_ctr_ff, frame_ff, timeout_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic           req_fire, rsp_free, apply_fire;
   logic           tier_ok;
   logic [TIW-1:0] tier_idx;
   logic [31:0]    use_next;

   slot_rec_type slot_rec [SLOTS+1];
   pend_rec_type pend_rec [PENDING+1];

   // Decisions taken from the chain tails.
   status_type         st;
   logic [IDX_W-1:0]   slot_sel;
   logic [COUNT_W-1:0] cnt;
   logic               do_touch, do_fill, p_clear, p_mark, frame_inc;
   logic [IDX_W-1:0]   victim;
   slot_rec_type       stail;
   pend_rec_type       ptail;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign apply_fire = (state_ff == S_APPLY) && rsp_free;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   assign tier_ok  = 32'(item_ff.tier) < TIERS;
   assign tier_idx = tier_ok ? TIW'(item_ff.tier) : '0;
   assign use_next = use_ctr_ff + 32'd1;

   assign slot_rec[0] = '{hit: 1'b0, hit_idx: '0, empty: 1'b0, empty_idx: '0,
                          min_stamp: '1, min_idx: '0, count: '0};
   assign pend_rec[0] = '{found: 1'b0, idx: '0, expired: 1'b0, free: 1'b0, free_idx: '0};

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      psrc_slot_cell #(.TIERS(TIERS), .INDEX(s)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tier_idx(tier_idx),
         .tier_ok (tier_ok),
         .key     (item_ff.lookup_key),
         .rec_i   (slot_rec[s]),
         .rec_o   (slot_rec[s+1]),
         .touch_en(apply_fire && do_touch && (slot_sel == IDX_W'(s))),
         .fill_en (apply_fire && do_fill && (slot_sel == IDX_W'(s))),
         .stamp   (use_next)
      );
   end

   for (genvar p = 0; p < PENDING; p++) begin : g_pend
      psrc_pend_cell #(.INDEX(p)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tier    (item_ff.tier),
         .key     (item_ff.lookup_key),
         .frame   (frame_ff),
         .timeout (timeout_ff),
         .rec_i   (pend_rec[p]),
         .rec_o   (pend_rec[p+1]),
         .clear_en(apply_fire && p_clear && (ptail.idx == IDX_W'(p))),
         .mark_en (apply_fire && p_mark && (ptail.free_idx == IDX_W'(p)))
      );
   end

   assign stail  = slot_rec[SLOTS];
   assign ptail  = pend_rec[PENDING];
   assign victim = stail.empty ? stail.empty_idx : stail.min_idx;

   always_comb begin
      st        = ST_TICK_DONE;
      slot_sel  = '0;
      cnt       = '0;
      do_touch  = 1'b0;
      do_fill   = 1'b0;
      p_clear   = 1'b0;
      p_mark    = 1'b0;
      frame_inc = 1'b0;
      unique case (kind_type'(item_ff.kind))
         K_TICK: begin
            st        = ST_TICK_DONE;
            frame_inc = 1'b1;
            cnt       = tier_ok ? stail.count : '0;
         end
         K_SYNC: begin
            if (!tier_ok) begin
               st = ST_BAD_TIER;
            end else if (stail.hit) begin
               st       = ST_HIT;
               slot_sel = stail.hit_idx;
               do_touch = 1'b1;
               cnt      = stail.count;
            end else begin
               st       = ST_FILLED;
               slot_sel = victim;
               do_fill  = 1'b1;
               cnt      = stail.count + COUNT_W'(stail.empty);
            end
         end
         K_ASYNC: begin
            if (!tier_ok) begin
               st = ST_BAD_TIER;
            end else if (stail.hit) begin
               st       = ST_HIT;
               slot_sel = stail.hit_idx;
               do_touch = 1'b1;
               cnt      = stail.count;
            end else begin
               cnt     = stail.count;
               p_clear = ptail.found && ptail.expired;
               if (ptail.found && !ptail.expired) begin
                  st = ST_PENDING;
               end else if (item_ff.queue_accepts) begin
                  st     = ST_ISSUED;
                  p_mark = ptail.free;
               end else begin
                  st = ST_REFUSED;
               end
            end
         end
         K_BAKE: begin
            if (!tier_ok) begin
               st = ST_BAD_TIER;
            end else begin
               st       = ST_FILLED;
               p_clear  = ptail.found;
               slot_sel = victim;
               do_fill  = 1'b1;
               cnt      = stail.count + COUNT_W'(stail.empty);
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_cnt_ff == CNT_W'(WALK - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      walk_cnt_in = '0;
      if (state_ff == S_WALK) begin
         walk_cnt_in = walk_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         walk_cnt_ff  <= '0;
         use_ctr_ff   <= '0;
         frame_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         walk_cnt_ff <= walk_cnt_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         if (apply_fire && (do_touch || do_fill)) begin
            use_ctr_ff <= use_next;
         end
         if (apply_fire && frame_inc) begin
            frame_ff <= frame_ff + 32'd1;
         end
         if (apply_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (apply_fire) begin
         rsp_data_ff.status         <= st;
         rsp_data_ff.slot           <= 4'(slot_sel);
         rsp_data_ff.resident_count <= 5'(cnt);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PSRC_ASSERT_NEXT(a_accept_walks, req_fire, state_ff == S_WALK,
      "accepted request did not start the chain walk")
   `PSRC_ASSERT_NEXT(a_use_ctr_quiet, !apply_fire, $stable(use_ctr_ff),
      "use counter moved outside an update")
   `PSRC_ASSERT_NOW(a_walk_bound, state_ff == S_WALK, walk_cnt_ff <= CNT_W'(WALK - 1),
      "walk counter ran past the chain length")

endmodule

// ----- verif/patch_slot_residency_cache_top_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Patch slot residency cache testbench
// Drives request beats through a directed table and then random traffic
// drawn from a small key pool. It predicts every response with its own model
// of the slot tables, LRU stamps and pending table, and checks each field.
// The pending timeout is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module patch_slot_residency_cache_top_test;
   import psrc_pkg::*;

   localparam int TIERS = TIERS_DEF;
   localparam int SLOTS = SLOTS_DEF;
   localparam int PENDING = PENDING_DEF;
   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE = 40;
   localparam int POOL = 24;

   typedef struct packed {
      req_type r;
      logic    typed;
      rsp_type e;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [31:0] csr_data = '0;

   // Model of the block state.
   logic        res_valid [TIERS*SLOTS];
   logic [63:0] res_key [TIERS*SLOTS];
   logic [31:0] res_stamp [TIERS*SLOTS];
   logic [31:0] use_count;
   logic [31:0] frame_no;
   logic        pend_used [PENDING];
   logic [2:0]  pend_tier [PENDING];
   logic [63:0] pend_key [PENDING];
   logic [31:0] pend_mark [PENDING];
   logic [31:0] timeout_frames;

   rsp_type expected_rsp [$];
   logic [63:0] key_pool [POOL];
   int errors = 0;
   int idle_cycles = 0;
   bit calm = 0;
   bit hold_off = 0;
   row_type directed [14];

   always #5 clock = ~clock;

   patch_slot_residency_cache_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   function automatic void clear_residency();
      for (int i = 0; i < TIERS*SLOTS; i++) begin
         res_valid[i] = 0;
         res_key[i] = '0;
         res_stamp[i] = '0;
      end
      for (int i = 0; i < PENDING; i++) begin
         pend_used[i] = 0;
         pend_tier[i] = '0;
         pend_key[i] = '0;
         pend_mark[i] = '0;
      end
      use_count = '0;
      frame_no = '0;
      timeout_frames = TIMEOUT_RESET;
   endfunction

   function automatic int fill_residency(int base, logic [63:0] key);
      int s;
      s = -1;
      for (int i = 0; i < SLOTS; i++)
         if (s < 0 && !res_valid[base+i]) s = i;
      if (s < 0) begin
         s = 0;
         for (int i = 1; i < SLOTS; i++)
            if (res_stamp[base+i] < res_stamp[base+s]) s = i;
      end
      res_valid[base+s] = 1;
      res_key[base+s] = key;
      use_count = use_count + 1;
      res_stamp[base+s] = use_count;
      return s;
   endfunction

   function automatic rsp_type predict_residency(req_type r);
      rsp_type o;
      bit tier_ok;
      int base;
      int hit;
      int p;
      bit still;
      o = '0;
      tier_ok = r.tier < TIERS;
      base = tier_ok ? r.tier * SLOTS : 0;
      hit = -1;
      p = -1;
      still = 0;
      if (tier_ok)
         for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && res_valid[base+i] && res_key[base+i] == r.lookup_key) hit = i;
      for (int i = 0; i < PENDING; i++)
         if (p < 0 && pend_used[i] && pend_tier[i] == r.tier && pend_key[i] == r.lookup_key)
            p = i;
      if (r.kind == K_TICK) begin
         frame_no = frame_no + 1;
         o.status = ST_TICK_DONE;
      end else if (!tier_ok) begin
         o.status = ST_BAD_TIER;
      end else if (r.kind != K_BAKE && hit >= 0) begin
         use_count = use_count + 1;
         res_stamp[base+hit] = use_count;
         o.slot = 4'(hit);
         o.status = ST_HIT;
      end else if (r.kind == K_SYNC) begin
         o.slot = 4'(fill_residency(base, r.lookup_key));
         o.status = ST_FILLED;
      end else if (r.kind == K_ASYNC) begin
         // An expired entry is released and the key counts as not pending.
         if (p >= 0) begin
            if (frame_no - pend_mark[p] > timeout_frames) pend_used[p] = 0;
            else still = 1;
         end
         if (still) begin
            o.status = ST_PENDING;
         end else if (r.queue_accepts) begin
            p = -1;
            for (int i = 0; i < PENDING; i++)
               if (p < 0 && !pend_used[i]) p = i;
            if (p >= 0) begin
               pend_used[p] = 1;
               pend_tier[p] = r.tier;
               pend_key[p] = r.lookup_key;
               pend_mark[p] = frame_no;
            end
            o.status = ST_ISSUED;
         end else begin
            o.status = ST_REFUSED;
         end
      end else begin
         if (p >= 0) pend_used[p] = 0;
         o.slot = 4'(fill_residency(base, r.lookup_key));
         o.status = ST_FILLED;
      end
      if (tier_ok && o.status != ST_BAD_TIER)
         for (int i = 0; i < SLOTS; i++)
            if (res_valid[base+i]) o.resident_count = o.resident_count + 5'd1;
      return o;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: response beat with nothing expected", $realtime);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_data.status != e.status)
               report_mismatch("status", rsp_data.status, e.status);
            if (rsp_data.slot != e.slot)
               report_mismatch("slot", rsp_data.slot, e.slot);
            if (rsp_data.resident_count != e.resident_count)
               report_mismatch("resident_count", rsp_data.resident_count, e.resident_count);
         end
      end
   end

   // Watchdog on cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off on request.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 0;
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(req_type r, bit typed, rsp_type want);
      rsp_type p;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_residency(r);
      expected_rsp.push_back(typed ? want : p);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic write_timeout(logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      timeout_frames = value;
   endtask

   function automatic req_type random_beat();
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.kind = pick < 35 ? K_SYNC : pick < 70 ? K_ASYNC : pick < 85 ? K_BAKE : K_TICK;
      r.tier = 3'($urandom_range(0, 9) == 0 ? $urandom_range(TIERS, 7)
                                            : $urandom_range(0, TIERS - 1));
      r.lookup_key = key_pool[$urandom_range(0, POOL - 1)];
      r.queue_accepts = $urandom_range(0, 3) != 0;
      return r;
   endfunction

   initial begin
      logic [31:0] settings [4];
      clear_residency();
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL; i++) key_pool[i] = {$urandom, $urandom};
      settings = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'd0};
      settings[3] = $urandom_range(1, 12);
      directed = '{
         '{'{K_SYNC, 3'd0, 64'd0, 1'b1}, 1'b1, '{ST_FILLED, 4'd0, 5'd1}},
         '{'{K_SYNC, 3'd0, 64'd0, 1'b0}, 1'b1, '{ST_HIT, 4'd0, 5'd1}},
         '{'{K_TICK, 3'd7, '1, 1'b1}, 1'b1, '{ST_TICK_DONE, 4'd0, 5'd0}},
         '{'{K_SYNC, 3'd4, '1, 1'b1}, 1'b1, '{ST_BAD_TIER, 4'd0, 5'd0}},
         '{'{K_ASYNC, 3'd5, 64'd9, 1'b1}, 1'b1, '{ST_BAD_TIER, 4'd0, 5'd0}},
         '{'{K_BAKE, 3'd7, 64'd9, 1'b0}, 1'b1, '{ST_BAD_TIER, 4'd0, 5'd0}},
         '{'{K_ASYNC, 3'd1, '1, 1'b0}, 1'b1, '{ST_REFUSED, 4'd0, 5'd0}},
         '{'{K_ASYNC, 3'd1, '1, 1'b1}, 1'b1, '{ST_ISSUED, 4'd0, 5'd0}},
         '{'{K_ASYNC, 3'd1, '1, 1'b1}, 1'b1, '{ST_PENDING, 4'd0, 5'd0}},
         '{'{K_BAKE, 3'd1, '1, 1'b0}, 1'b1, '{ST_FILLED, 4'd0, 5'd1}},
         '{'{K_BAKE, 3'd1, '1, 1'b1}, 1'b1, '{ST_FILLED, 4'd1, 5'd2}},
         '{'{K_TICK, 3'd1, 64'd0, 1'b0}, 1'b1, '{ST_TICK_DONE, 4'd0, 5'd2}},
         '{'{K_BAKE, 3'd2, 64'd5, 1'b1}, 1'b1, '{ST_FILLED, 4'd0, 5'd1}},
         '{'{K_ASYNC, 3'd3, 64'h8000_0000_0000_0001, 1'b1}, 1'b0, '0}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_beat(directed[i].r, directed[i].typed, directed[i].e);
      // Fill tier 3 past capacity so that the LRU victim choice is exercised.
      for (int i = 0; i < SLOTS + 3; i++)
         send_beat('{K_SYNC, 3'd3, key_pool[i], 1'b1}, 1'b0, '0);
      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) write_timeout(settings[ph-1]);
         calm = (ph == 4);
         for (int n = 0; n < 175; n++) begin
            if (ph == 1 && n == 20) hold_off = 1;
            send_beat(random_beat(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
